// ===== hdl/arcp_pkg.sv =====
// Shared constants and types of the rounded-corner pixel generator.
// No dependencies; every other file imports it.
`default_nettype none

package arcp_pkg;

    localparam int MAX_RADIUS   = 64;
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int COORD_W      = 6;
    localparam int RAD_W        = 7;
    localparam int COLOR_W      = 24;
    localparam int NUM_SAMPLES  = 4;
    localparam int SUB_W        = COORD_W + 2;              // quarter-pixel coordinate
    localparam int D2_W         = 2 * SUB_W + 1;            // squared distance
    localparam int CNT_W        = 3;                        // 0..4 samples
    localparam int CFG_IDX_W    = 3;
    localparam int ROUND_BIAS   = 2;                        // half of NUM_SAMPLES
    localparam int AVG_SHIFT    = 2;                        // log2 of NUM_SAMPLES
    localparam int BLEND_W      = CHANNEL_BITS + CNT_W;

    // Sub-sample offsets in quarter pixels
    localparam logic [1:0] SUB_X [NUM_SAMPLES] = '{2'd1, 2'd3, 2'd1, 2'd3};
    localparam logic [1:0] SUB_Y [NUM_SAMPLES] = '{2'd1, 2'd1, 2'd3, 2'd3};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 3'd0,
        REG_FILL     = 3'd1,
        REG_BORDER   = 3'd2,
        REG_OUTSIDE  = 3'd3,
        REG_MIRROR_X = 3'd4,
        REG_MIRROR_Y = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [RAD_W-1:0]   radius;
        logic [COLOR_W-1:0] fill_rgb;
        logic [COLOR_W-1:0] ring_rgb;
        logic [COLOR_W-1:0] bg_rgb;
        logic               mirror_x;
        logic               mirror_y;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0]                  col;
        logic [COORD_W-1:0]                  row;
        logic                                in_blk;
        logic [NUM_SAMPLES-1:0][D2_W-1:0]    d2;
        logic [D2_W-1:0]                     outer;
        logic [D2_W-1:0]                     inner;
    } t_dist;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               in_blk;
        logic [CNT_W-1:0]   nf;
        logic [CNT_W-1:0]   nb;
        logic [CNT_W-1:0]   no;
    } t_count;

endpackage

`default_nettype wire

// ===== hdl/aa_rounded_corner_pixel.sv =====
// Anti-aliased rounded-corner pixel generator, top level.
// Depends on arcp_pkg, arcp_cfg, arcp_dist, arcp_class, arcp_blend.
//
// Usage:
//  - s_axis carries one pixel coordinate per transfer (col, row inside the
//    r-by-r corner block). m_axis returns one transfer per input: the RGB888
//    colour, the echoed coordinate, and in tuser the inside flag (1 when both
//    coordinates are below the clamped radius).
//  - Colour from 2x2 supersampling; samples are classed fill / border /
//    outside against 16*r*r and 16*(r-1)^2.
//  - Config channel: index 0 radius, 1 fill, 2 border, 3 outside colour,
//    4 mirror_x, 5 mirror_y. Always ready; other indexes are dropped.
//    Write only while no pixel is in flight.
//  - Pipeline registers, in order from input transfer to output valid: offset,
//    square, classify, blend/output. Throughput: one pixel per clock while m_axis_tready is high.
//  - Stall: when m_axis_tready is low, full stages hold; empty stages
//    ahead of them still fill, so input is taken until the pipe is full.
//  - Reset (synchronous, active low): pipe emptied, radius = 8, colours and
//    mirror bits cleared.
`default_nettype none

module aa_rounded_corner_pixel (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pixel input
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [15:0]                       s_axis_tdata,   // [5:0] col, [11:6] row
    // pixel output
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [39:0]                            m_axis_tdata,   // [23:0] pixel_color,
                                                                   // [29:24] col_out,
                                                                   // [35:30] row_out
    output logic                                   m_axis_tuser,   // [0] inside_block
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [arcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [arcp_pkg::COLOR_W-1:0]      i_cfg_data
);
    import arcp_pkg::*;

    t_cfg               cfg;
    logic               dist_valid;
    logic               dist_ready;
    t_dist              dist_data;
    logic               cnt_valid;
    logic               cnt_ready;
    t_count             cnt_data;
    logic [COLOR_W-1:0] out_color;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;

    arcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    arcp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_col   (s_axis_tdata[COORD_W-1:0]),
        .i_row   (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .o_valid (dist_valid),
        .i_ready (dist_ready),
        .o_data  (dist_data)
    );

    arcp_class u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (dist_ready),
        .i_data  (dist_data),
        .o_valid (cnt_valid),
        .i_ready (cnt_ready),
        .o_data  (cnt_data)
    );

    arcp_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (cnt_valid),
        .o_ready  (cnt_ready),
        .i_data   (cnt_data),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_color  (out_color),
        .o_col    (out_col),
        .o_row    (out_row),
        .o_inside (m_axis_tuser)
    );

    // pad to whole bytes
    assign m_axis_tdata = {4'b0000, out_row, out_col, out_color};

endmodule

`default_nettype wire

// ===== hdl/arcp_cfg.sv =====
// Configuration register file of the rounded-corner pixel generator.
// Depends on arcp_pkg.
`default_nettype none

module arcp_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [arcp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [arcp_pkg::COLOR_W-1:0]     i_cfg_data,
    output arcp_pkg::t_cfg                        o_cfg
);
    import arcp_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius   <= RAD_W'(8);
            r_cfg.fill_rgb <= '0;
            r_cfg.ring_rgb <= '0;
            r_cfg.bg_rgb   <= '0;
            r_cfg.mirror_x <= 1'b0;
            r_cfg.mirror_y <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_RADIUS:   r_cfg.radius   <= i_cfg_data[RAD_W-1:0];
                REG_FILL:     r_cfg.fill_rgb <= i_cfg_data;
                REG_BORDER:   r_cfg.ring_rgb <= i_cfg_data;
                REG_OUTSIDE:  r_cfg.bg_rgb   <= i_cfg_data;
                REG_MIRROR_X: r_cfg.mirror_x <= i_cfg_data[0];
                REG_MIRROR_Y: r_cfg.mirror_y <= i_cfg_data[0];
                default: ;    // unmapped index, write dropped
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arcp_dist.sv =====
// Two pipeline stages: sample offsets from the centre, then squared distances
// and radius thresholds. Depends on arcp_pkg.
`default_nettype none

module arcp_dist (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire arcp_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [arcp_pkg::COORD_W-1:0]  i_col,
    input  wire logic [arcp_pkg::COORD_W-1:0]  i_row,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output arcp_pkg::t_dist                    o_data
);
    import arcp_pkg::*;

    // stage A: offsets
    logic                              r_a_v;
    logic [COORD_W-1:0]                r_a_col;
    logic [COORD_W-1:0]                r_a_row;
    logic                              r_a_inside;
    logic [RAD_W-1:0]                  r_a_rad;
    logic [NUM_SAMPLES-1:0][SUB_W-1:0] r_a_dx;
    logic [NUM_SAMPLES-1:0][SUB_W-1:0] r_a_dy;
    // stage B: squares
    logic                              r_b_v;
    t_dist                             r_b;

    logic                              a_ready;
    logic                              b_ready;
    logic [RAD_W-1:0]                  rad_sat;
    logic                              in_blk;
    logic [NUM_SAMPLES-1:0][SUB_W-1:0] n_dx;
    logic [NUM_SAMPLES-1:0][SUB_W-1:0] n_dy;
    logic [SUB_W:0]                    four_r;
    logic [SUB_W-1:0]                  sx;
    logic [SUB_W-1:0]                  sy;
    t_dist                             n_b;
    logic [2*SUB_W-1:0]                sq_x;
    logic [2*SUB_W-1:0]                sq_y;
    logic [RAD_W-1:0]                  rad_m1;
    logic [2*RAD_W-1:0]                r2;
    logic [2*RAD_W-1:0]                rm2;

    function automatic logic rad_in_range(input logic [RAD_W-1:0] rad);
        return rad <= RAD_W'(MAX_RADIUS);
    endfunction

    assign b_ready = !r_b_v || i_ready;
    assign a_ready = !r_a_v || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_v;
    assign o_data  = r_b;

    always_comb begin
        rad_sat = (rad_in_range(i_cfg.radius)) ? i_cfg.radius : RAD_W'(MAX_RADIUS);
        in_blk  = (rad_sat != '0) && ({1'b0, i_col} < rad_sat) && ({1'b0, i_row} < rad_sat);
        four_r  = {rad_sat, 2'b00};
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            sx = {i_col, SUB_X[s]};
            sy = {i_row, SUB_Y[s]};
            // distance is measured from the corner's circle centre
            n_dx[s] = i_cfg.mirror_x ? sx : SUB_W'(four_r - {1'b0, sx});
            n_dy[s] = i_cfg.mirror_y ? sy : SUB_W'(four_r - {1'b0, sy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_ready) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_col    <= i_col;
            r_a_row    <= i_row;
            r_a_inside <= in_blk;
            r_a_rad    <= rad_sat;
            r_a_dx     <= n_dx;
            r_a_dy     <= n_dy;
        end
    end

    always_comb begin
        n_b.col    = r_a_col;
        n_b.row    = r_a_row;
        n_b.in_blk = r_a_inside;
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            sq_x     = r_a_dx[s] * r_a_dx[s];
            sq_y     = r_a_dy[s] * r_a_dy[s];
            n_b.d2[s] = {1'b0, sq_x} + {1'b0, sq_y};
        end
        rad_m1    = r_a_rad - RAD_W'(1);
        r2        = r_a_rad * r_a_rad;
        rm2       = rad_m1 * rad_m1;
        n_b.outer = D2_W'({r2, 4'b0000});
        n_b.inner = D2_W'({rm2, 4'b0000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_ready) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_v) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arcp_class.sv =====
// Pipeline stage that classes each sample as fill, border or outside and
// counts the classes. Depends on arcp_pkg.
`default_nettype none

module arcp_class (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire arcp_pkg::t_dist    i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output arcp_pkg::t_count        o_data
);
    import arcp_pkg::*;

    logic   r_v;
    t_count r_cnt;
    t_count n_cnt;
    logic   ready;

    assign ready   = !r_v || i_ready;
    assign o_ready = ready;
    assign o_valid = r_v;
    assign o_data  = r_cnt;

    always_comb begin
        n_cnt.col    = i_data.col;
        n_cnt.row    = i_data.row;
        n_cnt.in_blk = i_data.in_blk;
        n_cnt.nf     = '0;
        n_cnt.nb     = '0;
        n_cnt.no     = '0;
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            if (i_data.d2[s] > i_data.outer) begin
                n_cnt.no = n_cnt.no + CNT_W'(1);
            end else if (i_data.d2[s] > i_data.inner) begin
                n_cnt.nb = n_cnt.nb + CNT_W'(1);
            end else begin
                n_cnt.nf = n_cnt.nf + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arcp_blend.sv =====
// Final pipeline stage and output register: colour select or per-channel
// rounded blend. Depends on arcp_pkg.
`default_nettype none

module arcp_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire arcp_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire arcp_pkg::t_count              i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [arcp_pkg::COLOR_W-1:0]       o_color,
    output logic [arcp_pkg::COORD_W-1:0]       o_col,
    output logic [arcp_pkg::COORD_W-1:0]       o_row,
    output logic                               o_inside
);
    import arcp_pkg::*;

    logic                    r_v;
    logic [COLOR_W-1:0]      r_color;
    logic [COORD_W-1:0]      r_col;
    logic [COORD_W-1:0]      r_row;
    logic                    r_inside;

    logic                    ready;
    logic [COLOR_W-1:0]      n_color;
    logic [COLOR_W-1:0]      mix;
    logic [BLEND_W-1:0]      acc;

    assign ready    = !r_v || i_ready;
    assign o_ready  = ready;
    assign o_valid  = r_v;
    assign o_color  = r_color;
    assign o_col    = r_col;
    assign o_row    = r_row;
    assign o_inside = r_inside;

    always_comb begin
        mix = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            acc = BLEND_W'(i_cfg.fill_rgb[c*CHANNEL_BITS +: CHANNEL_BITS]) * BLEND_W'(i_data.nf)
                + BLEND_W'(i_cfg.ring_rgb[c*CHANNEL_BITS +: CHANNEL_BITS]) * BLEND_W'(i_data.nb)
                + BLEND_W'(i_cfg.bg_rgb[c*CHANNEL_BITS +: CHANNEL_BITS]) * BLEND_W'(i_data.no)
                + BLEND_W'(ROUND_BIAS);
            mix[c*CHANNEL_BITS +: CHANNEL_BITS] = acc[AVG_SHIFT +: CHANNEL_BITS];
        end

        if (!i_data.in_blk) begin
            n_color = i_cfg.bg_rgb;
        end else if (i_data.nf == CNT_W'(NUM_SAMPLES)) begin
            n_color = i_cfg.fill_rgb;
        end else if (i_data.no == CNT_W'(NUM_SAMPLES)) begin
            n_color = i_cfg.bg_rgb;
        end else if (i_data.nb == CNT_W'(NUM_SAMPLES)) begin
            n_color = i_cfg.ring_rgb;
        end else begin
            n_color = mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_color  <= n_color;
            r_col    <= i_data.col;
            r_row    <= i_data.row;
            r_inside <= i_data.in_blk;
        end
    end

endmodule

`default_nettype wire
